>>> rtl/rotate_pose_about_local_y_axis_macros.svh
// ---------------------------------------------------------------------------
// rotate_pose_about_local_y_axis_macros
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ROTATE_POSE_ABOUT_LOCAL_Y_AXIS_MACROS_SVH
`define ROTATE_POSE_ABOUT_LOCAL_Y_AXIS_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RPY_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RPY_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/rpy_pkg.sv
// ---------------------------------------------------------------------------
// rpy_pkg
// Types, constants and helpers for the local-y pose rotation block.
// ---------------------------------------------------------------------------
package rpy_pkg;
  localparam int CordicStepsDefault = 16;
  localparam int AtanCount = 24;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [31:0] GainInvQ30 = 32'sd652032874;

  typedef logic signed [15:0] entry_t;

  typedef struct packed {
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    entry_t c;
    entry_t s;
  } trig_t;

  function automatic logic signed [31:0] atan_at(input int i);
    logic signed [31:0] t [AtanCount];
    t = '{32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
          32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
          32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
          32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430,
          32'sd5215, 32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81};
    return t[i];
  endfunction

  function automatic entry_t sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

>>> rtl/rpy_if.sv
// ---------------------------------------------------------------------------
// rpy_stream_if
// Valid/ready channel carrying one payload type.
// ---------------------------------------------------------------------------
interface rpy_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rpy_trig.sv
// ---------------------------------------------------------------------------
// rpy_trig
// Cosine and sine of the configured angle by CORDIC; recomputed after writes.
// ---------------------------------------------------------------------------
module rpy_trig import rpy_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic signed [15:0] angle,
  input  logic        start,
  output trig_t       trig,
  output logic        busy
);
  localparam int Steps = (CORDIC_STEPS > AtanCount) ? AtanCount : CORDIC_STEPS;
  localparam int CntW = $clog2(AtanCount + 1);

  logic signed [33:0] x, y, z;
  logic [CntW-1:0] cnt;
  logic flip, run, finish;
  logic signed [33:0] dx, dy, xr, yr;
  logic signed [16:0] ared;
  logic signed [17:0] xq, yq;
  entry_t cc, ss;

  assign dx = x >>> cnt;
  assign dy = y >>> cnt;
  assign busy = run | finish | start;

  always_comb begin
    if (angle >= 16'sd16384) ared = 17'(angle) - 17'sd32768;
    else if (angle < -16'sd16384) ared = 17'(angle) + 17'sd32768;
    else ared = 17'(angle);
    xr = x + 34'sd32768;
    yr = y + 34'sd32768;
    xq = xr[33:16];
    yq = yr[33:16];
    cc = (xq > 18'sd16384) ? OneQ14 : (xq < -18'sd16384) ? -OneQ14 : xq[15:0];
    ss = (yq > 18'sd16384) ? OneQ14 : (yq < -18'sd16384) ? -OneQ14 : yq[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      finish <= 1'b0;
      trig <= '{c: OneQ14, s: 16'sd0};
    end else if (start) begin
      run <= 1'b1;
      finish <= 1'b0;
      cnt <= '0;
      flip <= (angle >= 16'sd16384) || (angle < -16'sd16384);
      z <= 34'(ared) <<< 16;
      x <= 34'(GainInvQ30);
      y <= '0;
    end else if (run) begin
      if (z >= 0) begin
        x <= x - dy; y <= y + dx; z <= z - 34'(atan_at(int'(cnt)));
      end else begin
        x <= x + dy; y <= y - dx; z <= z + 34'(atan_at(int'(cnt)));
      end
      cnt <= cnt + 1'b1;
      if (cnt == CntW'(Steps - 1)) begin
        run <= 1'b0;
        finish <= 1'b1;
      end
    end else if (finish) begin
      finish <= 1'b0;
      trig.c <= flip ? -cc : cc;
      trig.s <= flip ? -ss : ss;
    end
  end
endmodule

>>> rtl/rpy_rodrigues.sv
// ---------------------------------------------------------------------------
// rpy_rodrigues
// Two pipeline stages: axis products, then Rodrigues matrix entries.
// ---------------------------------------------------------------------------
module rpy_rodrigues import rpy_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mat_t  m_in,
  input  trig_t trig,
  output mat_t  m_out,
  output mat_t  a_out
);
  logic signed [31:0] p00, p01, p02, p11, p12, p22, s0, s1, s2;
  logic signed [16:0] omc;
  entry_t c;
  mat_t m1;

  function automatic entry_t rod(input logic signed [31:0] vv,
                                 input logic signed [16:0] om,
                                 input logic signed [15:0] dg,
                                 input logic signed [31:0] cr);
    logic signed [63:0] acc;
    acc = 64'(vv) * 64'(om) + (64'(dg) <<< 28) + (64'(cr) <<< 14) + 64'sd134217728;
    return sat16(48'(acc >>> 28));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= 32'(m_in.m01) * 32'(m_in.m01);
      p01 <= 32'(m_in.m01) * 32'(m_in.m11);
      p02 <= 32'(m_in.m01) * 32'(m_in.m21);
      p11 <= 32'(m_in.m11) * 32'(m_in.m11);
      p12 <= 32'(m_in.m11) * 32'(m_in.m21);
      p22 <= 32'(m_in.m21) * 32'(m_in.m21);
      s0 <= 32'(m_in.m01) * 32'(trig.s);
      s1 <= 32'(m_in.m11) * 32'(trig.s);
      s2 <= 32'(m_in.m21) * 32'(trig.s);
      omc <= 17'sd16384 - 17'(trig.c);
      c <= trig.c;
      m1 <= m_in;
      m_out <= m1;
      a_out.m00 <= rod(p00, omc, c, 32'sd0);
      a_out.m01 <= rod(p01, omc, 16'sd0, -s2);
      a_out.m02 <= rod(p02, omc, 16'sd0, s1);
      a_out.m10 <= rod(p01, omc, 16'sd0, s2);
      a_out.m11 <= rod(p11, omc, c, 32'sd0);
      a_out.m12 <= rod(p12, omc, 16'sd0, -s0);
      a_out.m20 <= rod(p02, omc, 16'sd0, -s1);
      a_out.m21 <= rod(p12, omc, 16'sd0, s0);
      a_out.m22 <= rod(p22, omc, c, 32'sd0);
    end
  end
endmodule

>>> rtl/rpy_matmul.sv
// ---------------------------------------------------------------------------
// rpy_matmul
// Two pipeline stages: 27 products, then sums with rounding and saturation.
// ---------------------------------------------------------------------------
module rpy_matmul import rpy_pkg::*; (
  input  logic clk,
  input  logic en,
  input  mat_t m,
  input  mat_t a,
  output mat_t r
);
  logic signed [31:0] p [9][3];
  entry_t me [9];
  entry_t ae [9];
  entry_t re [9];
  logic signed [33:0] acc [9];

  assign me = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
  assign ae = '{a.m00, a.m01, a.m02, a.m10, a.m11, a.m12, a.m20, a.m21, a.m22};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            p[i*3+j][k] <= 32'(me[i*3+k]) * 32'(ae[k*3+j]);
    end
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      acc[n] = 34'(p[n][0]) + 34'(p[n][1]) + 34'(p[n][2]) + 34'sd8192;
      re[n] = sat16(48'(acc[n] >>> 14));
    end
  end

  always_ff @(posedge clk) begin
    if (en) r <= '{re[0], re[1], re[2], re[3], re[4], re[5], re[6], re[7], re[8]};
  end
endmodule

>>> rtl/rotate_pose_about_local_y_axis.sv
// Registered stages: axis products, Rodrigues entries, matrix products, sums; throughput 1 pose/cycle unless stalled.
// The pipeline stalls as a whole when the output holds a result not taken.
// A config write retriggers the CORDIC; input stays not ready until cosine
// and sine are fresh.
// Reset (rst, synchronous) empties the pipeline and sets cos 1, sin 0.
// ---------------------------------------------------------------------------
// rotate_pose_about_local_y_axis
// Rotates a 3x3 pose rotation about its own y axis by a configured angle.
// ---------------------------------------------------------------------------
module rotate_pose_about_local_y_axis import rpy_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input logic clk,
  input logic rst,
  rpy_stream_if.sink   cfg,
  rpy_stream_if.sink   in_pose,
  rpy_stream_if.source out_pose
);
  logic [3:0] vld;   // valid bit per stage
  logic adv;         // whole pipe moves
  logic busy;
  trig_t trig;
  mat_t m_s0, m_mid, a_mid;

  // Pipe advances unless the last stage holds an untaken result.
  assign adv = !vld[3] || out_pose.ready;
  assign in_pose.ready = adv && !busy;
  assign cfg.ready = 1'b1;
  assign out_pose.valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[2:0], in_pose.valid && in_pose.ready};
  end

  assign m_s0 = in_pose.data;

  rpy_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig (
    .clk, .rst, .angle(cfg.data), .start(cfg.valid), .trig, .busy
  );

  rpy_rodrigues u_rod (
    .clk, .en(adv), .m_in(m_s0), .trig, .m_out(m_mid), .a_out(a_mid)
  );

  rpy_matmul u_mul (
    .clk, .en(adv), .m(m_mid), .a(a_mid), .r(out_pose.data)
  );
endmodule

>>> rtl/rpy_checker.sv
// ---------------------------------------------------------------------------
// rpy_checker
// Port-level checks of the pose rotation block.
// ---------------------------------------------------------------------------
`include "rotate_pose_about_local_y_axis_macros.svh"
module rpy_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid
);
  `RPY_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `RPY_ASSERT_NEXT(a_cfg_blocks, clk, rst, cfg_valid, !in_ready, "input open during trig update")
  `RPY_ASSERT_IMPL(a_stall, clk, rst, out_valid && !out_ready, !(in_valid && in_ready), "stall")
endmodule

bind rotate_pose_about_local_y_axis rpy_checker u_chk (
  .clk, .rst, .in_valid(in_pose.valid), .in_ready(in_pose.ready),
  .out_valid(out_pose.valid), .out_ready(out_pose.ready), .cfg_valid(cfg.valid)
);

>>> bench/tb_rpy_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rpy_if
// Bench-side note: the stream interface itself comes from the RTL; this file
// carries the payload type used for the angle write channel.
// ---------------------------------------------------------------------------
package tb_rpy_types;
  typedef logic signed [15:0] angle_t;
endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the local-y pose rotation against a bit-exact predictor: directed
// extremes, random poses at several angles, random stalls, and a long
// output hold-off that backs the pipeline up.
// ---------------------------------------------------------------------------
module tb;
  import rpy_pkg::*;
  import tb_rpy_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rpy_stream_if #(.payload_t(angle_t)) cfg ();
  rpy_stream_if #(.payload_t(mat_t))   in_pose ();
  rpy_stream_if #(.payload_t(mat_t))   out_pose ();

  rotate_pose_about_local_y_axis i_dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .in_pose(in_pose.sink),
    .out_pose(out_pose.source)
  );

  // predictor copy of the angle register
  angle_t angle_reg = '0;
  mat_t expected_poses[$];
  int errors = 0;
  bit stall_free = 0;   // no random idling on either side
  int hold_cycles = 0;  // receiver hold-off request

  // floor shift on signed 64-bit values
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // CORDIC cosine/sine of the configured angle, Q1.14
  task automatic angle_trig(output longint c, output longint s);
    longint a, x, y, z, nx, ny, dx, dy;
    longint atab [24];
    bit flip;
    atab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
             10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
             41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    a = angle_reg;
    flip = 0;
    if (a >= 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    z = a * 65536;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicStepsDefault && i < AtanCount; i++) begin
      dx = fshr(x, i);
      dy = fshr(y, i);
      if (z >= 0) begin
        nx = x - dy; ny = y + dx; z -= atab[i];
      end else begin
        nx = x + dy; ny = y - dx; z += atab[i];
      end
      x = nx;
      y = ny;
    end
    c = unit_clamp(fshr(x + 32768, 16));
    s = unit_clamp(fshr(y + 32768, 16));
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint rod(longint vi, longint vj, longint omc, longint dg,
                                 longint cr);
    return sat(fshr(vi * vj * omc + dg * 268435456 + cr * 16384 + 134217728, 28));
  endfunction

  task automatic rotated_pose(input mat_t p, output mat_t r);
    longint m [3][3];
    longint a [3][3];
    longint rr [9];
    longint c, s, omc, v0, v1, v2, acc;
    m = '{'{p.m00, p.m01, p.m02}, '{p.m10, p.m11, p.m12}, '{p.m20, p.m21, p.m22}};
    angle_trig(c, s);
    omc = 16384 - c;
    v0 = m[0][1]; v1 = m[1][1]; v2 = m[2][1];
    a[0][0] = rod(v0, v0, omc, c, 0);
    a[0][1] = rod(v0, v1, omc, 0, -v2 * s);
    a[0][2] = rod(v0, v2, omc, 0, v1 * s);
    a[1][0] = rod(v1, v0, omc, 0, v2 * s);
    a[1][1] = rod(v1, v1, omc, c, 0);
    a[1][2] = rod(v1, v2, omc, 0, -v0 * s);
    a[2][0] = rod(v2, v0, omc, 0, -v1 * s);
    a[2][1] = rod(v2, v1, omc, 0, v0 * s);
    a[2][2] = rod(v2, v2, omc, c, 0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += m[i][k] * a[k][j];
        rr[i * 3 + j] = sat(fshr(acc + 8192, 14));
      end
    for (int i = 0; i < 9; i++) r[(8 - i) * 16 +: 16] = 16'(rr[i]);
  endtask

  initial begin
    cfg.valid = 0;
    cfg.data = '0;
    in_pose.valid = 0;
    in_pose.data = '0;
    out_pose.ready = 0;
  end

  // one pose transfer; inputs move on the falling edge
  task automatic send_pose(input mat_t p);
    mat_t r;
    while (!stall_free && $urandom_range(99) < 7) @(negedge clk);
    in_pose.data = p;
    in_pose.valid = 1;
    @(posedge clk);
    while (!in_pose.ready) @(posedge clk);
    rotated_pose(p, r);
    expected_poses.push_back(r);
    @(negedge clk);
    in_pose.valid = 0;
  endtask

  // only while idle: drain, let the pipe settle, then write
  task automatic write_angle(input angle_t ang);
    wait_idle();
    cfg.data = ang;
    cfg.valid = 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    angle_reg = ang;
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic wait_idle();
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic mat_t rand_pose();
    mat_t p;
    for (int i = 0; i < 9; i++) p[i * 16 +: 16] = 16'($urandom);
    return p;
  endfunction

  // near-unit pose: entries within about one, the common use case
  function automatic mat_t unit_pose();
    mat_t p;
    for (int i = 0; i < 9; i++) p[i * 16 +: 16] = 16'($urandom_range(32768) - 16384);
    return p;
  endfunction

  // receiver: random stalls, plus an explicit long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_pose.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_pose.ready <= stall_free || ($urandom_range(99) >= 7);
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    mat_t e, g;
    if (!rst && out_pose.valid && out_pose.ready) begin
      g = out_pose.data;
      if (expected_poses.size() == 0) begin
        $error("unexpected result transfer %h", g);
        errors++;
      end else begin
        e = expected_poses.pop_front();
        for (int f = 0; f < 9; f++)
          if (e[(8 - f) * 16 +: 16] !== g[(8 - f) * 16 +: 16]) begin
            $error("r%0d%0d expected %0d actual %0d", f / 3, f % 3,
                   $signed(e[(8 - f) * 16 +: 16]), $signed(g[(8 - f) * 16 +: 16]));
            errors++;
          end
      end
    end
  end

  task automatic test_directed();
    mat_t p;
    entry_t ext [4];
    entry_t z;
    z = 16'sd0;
    ext = '{16'sh7fff, 16'sh8000, 16'sd0, OneQ14};
    send_pose('{OneQ14, z, z, z, OneQ14, z, z, z, OneQ14});
    foreach (ext[i]) begin
      p = '{ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i]};
      send_pose(p);
    end
    send_pose('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                16'sh7fff, 16'sh8000, 16'sh7fff});
    send_pose('{z, 16'sh8000, z, z, 16'sh7fff, z, z, 16'sh8000, z});
    send_pose('{z, OneQ14, z, -OneQ14, z, z, z, z, OneQ14});
  endtask

  task automatic test_angles();
    // reduction edges and range extremes
    angle_t angs [10];
    entry_t z;
    z = 16'sd0;
    angs = '{16'sd16384, 16'sd16383, -16'sd16384, -16'sd16385, 16'sh7fff,
             16'sh8000, 16'sd8192, -16'sd8192, 16'sd1, 16'sd0};
    foreach (angs[i]) begin
      write_angle(angs[i]);
      send_pose('{OneQ14, z, z, z, OneQ14, z, z, z, OneQ14});
      send_pose(unit_pose());
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_angle(16'($urandom));
      for (int n = 0; n < 45; n++)
        send_pose(($urandom_range(3) == 0) ? rand_pose() : unit_pose());
    end
  endtask

  task automatic test_stall_free();
    stall_free = 1;
    for (int n = 0; n < 40; n++) send_pose(unit_pose());
    stall_free = 0;
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 60;
    for (int n = 0; n < 30; n++) send_pose(rand_pose());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_angles();
    test_random();
    test_stall_free();
    test_backpressure();
    write_angle(16'sh8000);
    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end
endmodule
